@@ rtl/mrw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin witness test package
// Shared widths, defaults and the controller state type.
// ----------------------------------------------------------------------------
package mrw_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int MOD_BITS      = 63;
    localparam int BASE_BITS     = 64;
    localparam int IN_BYTES_BITS = 128;
    localparam int OUT_BITS      = 8;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_RED    = 12'b0000_0000_0010,
        ST_RSQ    = 12'b0000_0000_0100,
        ST_DECOMP = 12'b0000_0000_1000,
        ST_MONE   = 12'b0000_0001_0000,
        ST_MBM    = 12'b0000_0010_0000,
        ST_EXPC   = 12'b0000_0100_0000,
        ST_EXPX   = 12'b0000_1000_0000,
        ST_EXPB   = 12'b0001_0000_0000,
        ST_CHK    = 12'b0010_0000_0000,
        ST_SQC    = 12'b0100_0000_0000,
        ST_SQ     = 12'b1000_0000_0000
    } t_state;

endpackage

@@ rtl/mrw_mont.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial Montgomery multiplier
// Computes x*y/2^W mod n, one multiplier bit per cycle, then one final
// conditional subtraction.
// ----------------------------------------------------------------------------
module mrw_mont #(
    parameter int W = mrw_pkg::WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_n,
    output logic         o_done,
    output logic [W-1:0] o_res
);
    import mrw_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W:0]    r_t;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_n;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_fin;
    logic          r_done;
    logic [W-1:0]  r_res;
    logic [W+1:0]  n_s1;
    logic [W+1:0]  n_s2;
    logic [W:0]    n_red;

    always_comb begin
        n_s1  = {1'b0, r_t} + (r_x[0] ? {2'b00, r_y} : '0);
        n_s2  = n_s1 + (n_s1[0] ? {2'b00, r_n} : '0);
        n_red = (r_t >= {1'b0, r_n}) ? (r_t - {1'b0, r_n}) : r_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_t    <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_n    <= i_n;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_t   <= n_s2[W+1:1];
                r_x   <= r_x >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_res  <= n_red[W-1:0];
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ rtl/miller_rabin_witness_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin witness test
// One strong-probable-prime round of an odd modulus to a given base, with
// bit-serial Montgomery arithmetic.
//
// Channel   Direction  Word contents
// s_axis    in         modulus [62:0], base [126:63]
// m_axis    out        probable_prime [0], input_error [1]
//
// A word passes through the base reduction, R^2 mod n and the splitting of
// n-1, then runs each Montgomery product on the single bit-serial
// multiplier; a 63-bit modulus needs at most 126 products.
// A bad modulus skips the arithmetic and is queued as a pending result.
// Reset is synchronous and clears all control state. One word is in work at
// a time; a finished result waits in the output register until taken.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test #(
    parameter int WORD_BITS = mrw_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // modulus [62:0], base [126:63], zero [127]
    input  logic [mrw_pkg::IN_BYTES_BITS-1:0] i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // probable_prime [0], input_error [1], zero [7:2]
    output logic [mrw_pkg::OUT_BITS-1:0]      o_m_axis_tdata
);
    import mrw_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int CMAX = (2 * W > BASE_BITS) ? 2 * W : BASE_BITS;
    localparam int CW   = $clog2(CMAX + 1);
    localparam int RW   = $clog2(W + 1);

    t_state              r_state;
    logic [W-1:0]        r_n;
    logic [BASE_BITS-1:0] r_a;
    logic [W-1:0]        r_v;
    logic [W-1:0]        r_rs;
    logic [W-1:0]        r_d;
    logic [W-1:0]        r_e;
    logic [W-1:0]        r_one;
    logic [W-1:0]        r_x;
    logic [W-1:0]        r_b;
    logic [CW-1:0]       r_cnt;
    logic [RW-1:0]       r_r;
    logic [RW-1:0]       r_i;
    logic                r_mst;
    logic                r_pend;
    logic                r_pp;
    logic                r_err;
    logic                r_ovalid;
    logic                r_opp;
    logic                r_oerr;

    logic [MOD_BITS-1:0] n_mod;
    logic [W-1:0]        n_nin;
    logic                n_bad;
    logic                n_acc;
    logic [W:0]          n_rtmp;
    logic [W-1:0]        n_rv;
    logic [W:0]          n_dtmp;
    logic [W-1:0]        n_drs;
    logic [W-1:0]        n_neg;
    logic [W-1:0]        n_mx;
    logic [W-1:0]        n_my;
    logic                m_done;
    logic [W-1:0]        m_res;
    logic                n_oload;

    always_comb begin
        n_mod  = i_s_axis_tdata[MOD_BITS-1:0];
        n_nin  = W'({1'b0, n_mod});
        n_bad  = !n_mod[0] || (n_mod < MOD_BITS'(3)) || ((n_mod >> (W - 1)) != '0);
        n_acc  = i_s_axis_tvalid && o_s_axis_tready;
        n_rtmp = {r_v, r_a[BASE_BITS-1]};
        n_rv   = (n_rtmp >= {1'b0, r_n}) ? W'(n_rtmp - {1'b0, r_n}) : r_v[W-1:0] << 1 |
                 W'(r_a[BASE_BITS-1]);
        n_dtmp = {r_rs, 1'b0};
        n_drs  = (n_dtmp >= {1'b0, r_n}) ? W'(n_dtmp - {1'b0, r_n}) : n_dtmp[W-1:0];
        n_neg  = r_n - r_one;
        case (r_state)
            ST_MONE: begin
                n_mx = r_rs;
                n_my = W'(1);
            end
            ST_MBM: begin
                n_mx = r_v;
                n_my = r_rs;
            end
            ST_EXPX: begin
                n_mx = r_x;
                n_my = r_b;
            end
            ST_EXPB: begin
                n_mx = r_b;
                n_my = r_b;
            end
            default: begin
                n_mx = r_x;
                n_my = r_x;
            end
        endcase
        n_oload = r_pend && (!r_ovalid || i_m_axis_tready);
    end

    mrw_mont #(.W(W)) u_mont (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mst),
        .i_x     (n_mx),
        .i_y     (n_my),
        .i_n     (r_n),
        .o_done  (m_done),
        .o_res   (m_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mst    <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_r      <= '0;
            r_i      <= '0;
        end else begin
            r_mst <= 1'b0;
            if (n_oload) begin
                r_ovalid <= 1'b1;
                r_opp    <= r_pp;
                r_oerr   <= r_err;
                r_pend   <= 1'b0;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_acc) begin
                        r_n   <= n_nin;
                        r_a   <= i_s_axis_tdata[MOD_BITS+BASE_BITS-1:MOD_BITS];
                        r_v   <= '0;
                        r_cnt <= CW'(BASE_BITS);
                        if (n_bad) begin
                            r_pp   <= 1'b0;
                            r_err  <= 1'b1;
                            r_pend <= 1'b1;
                        end else begin
                            r_err   <= 1'b0;
                            r_state <= ST_RED;
                        end
                    end
                end
                ST_RED: begin
                    r_v   <= n_rv;
                    r_a   <= r_a << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        if (n_rv == '0) begin
                            r_pp    <= 1'b1;
                            r_pend  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_rs    <= W'(1);
                            r_cnt   <= CW'(2 * W);
                            r_state <= ST_RSQ;
                        end
                    end
                end
                ST_RSQ: begin
                    r_rs  <= n_drs;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_d     <= r_n - W'(1);
                        r_r     <= '0;
                        r_state <= ST_DECOMP;
                    end
                end
                ST_DECOMP: begin
                    if (!r_d[0]) begin
                        r_d <= r_d >> 1;
                        r_r <= r_r + 1'b1;
                    end else begin
                        r_mst   <= 1'b1;
                        r_state <= ST_MONE;
                    end
                end
                ST_MONE: begin
                    if (m_done) begin
                        r_one   <= m_res;
                        r_mst   <= 1'b1;
                        r_state <= ST_MBM;
                    end
                end
                ST_MBM: begin
                    if (m_done) begin
                        r_b     <= m_res;
                        r_x     <= r_one;
                        r_e     <= r_d;
                        r_state <= ST_EXPC;
                    end
                end
                ST_EXPC: begin
                    if (r_e == '0) begin
                        r_state <= ST_CHK;
                    end else if (r_e[0]) begin
                        r_mst   <= 1'b1;
                        r_state <= ST_EXPX;
                    end else begin
                        r_mst   <= 1'b1;
                        r_state <= ST_EXPB;
                    end
                end
                ST_EXPX: begin
                    if (m_done) begin
                        r_x     <= m_res;
                        r_mst   <= 1'b1;
                        r_state <= ST_EXPB;
                    end
                end
                ST_EXPB: begin
                    if (m_done) begin
                        r_b     <= m_res;
                        r_e     <= r_e >> 1;
                        r_state <= ST_EXPC;
                    end
                end
                ST_CHK: begin
                    if (r_x == r_one || r_x == n_neg) begin
                        r_pp    <= 1'b1;
                        r_pend  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_i     <= RW'(1);
                        r_state <= ST_SQC;
                    end
                end
                ST_SQC: begin
                    if (r_i >= r_r) begin
                        r_pp    <= 1'b0;
                        r_pend  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_mst   <= 1'b1;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (m_done) begin
                        r_x <= m_res;
                        r_i <= r_i + 1'b1;
                        if (m_res == n_neg) begin
                            r_pp    <= 1'b1;
                            r_pend  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else if (m_res == r_one) begin
                            r_pp    <= 1'b0;
                            r_pend  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_SQC;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_pend;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{(OUT_BITS - 2){1'b0}}, r_oerr, r_opp};

endmodule

@@ rtl/mrw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin witness test port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module mrw_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [mrw_pkg::OUT_BITS-1:0]      o_m_axis_tdata
);
    import mrw_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready stayed high after a word was accepted");

    a_error_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]))
        else $error("result flags both an input error and a probable prime");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

endmodule

bind miller_rabin_witness_test mrw_checker u_mrw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
